// File: src/gnos_pkg.sv
// shared types and constants for the grid nearest obstacle search
// no dependencies; imported by every module of the block but gnos_ram
`default_nettype none

package gnos_pkg;

    localparam int CW      = 20;   // signed map column/row width
    localparam int ENT_AW  = 24;   // store address width carried in the queue
    localparam int DW      = 6;    // signed window offset width
    localparam int SQW     = 11;   // raw squared offset width
    localparam int ROOT_STEPS = 16;

    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;
    localparam logic [7:0] OCCUPIED_VALUE = 8'd100;
    localparam logic [9:0] SQ_MAX = 10'd1023;

    localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CPM        = 3'd2;
    localparam logic [2:0] REG_ORIGIN_COL = 3'd3;
    localparam logic [2:0] REG_ORIGIN_ROW = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic                  is_query;
        logic                  ld_en;
        logic                  ld_bit;
        logic [ENT_AW-1:0]     addr;
        logic signed [CW-1:0]  col;
        logic signed [CW-1:0]  row;
    } queue_entry_t;

endpackage

`default_nettype wire

// File: src/grid_nearest_obstacle_search.sv
// top level of the grid nearest obstacle search: config registers, front, queue, back
// depends on gnos_pkg, gnos_front, gnos_queue, gnos_back
//
// channel   direction  signals                          contents
// s_        in         s_tvalid s_tready s_tdata s_tuser load cell or query point
// m_        out        m_tvalid m_tready m_tdata         one result per query
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// after the front stage register, a load is written in the back part as it is popped; a query
// is popped, scans every cell of the (2*SEARCH_RADIUS+1)^2 window, drains the store read
// pipeline, takes sixteen square root steps and then loads the result register.
// the store delivers one cell per cycle during the scan. results register at the output,
// so the back part moves on while a result waits. the occupancy store has no clearing pass.
`default_nettype none

module grid_nearest_obstacle_search import gnos_pkg::*; #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int SEARCH_RADIUS = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // cell_index, cell_value, point_x, point_y
    input  wire logic         s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // found, squared_distance, distance, zero fill
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);

    logic [8:0]   n_cols_reg, n_rows_reg;
    logic [23:0]  cpm_reg, origin_col_reg, origin_row_reg;

    queue_entry_t push_data, head;
    logic         push, full, pop, empty;
    logic         r_found;
    logic [9:0]   r_sq;
    logic [14:0]  r_dist;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_cols_reg     <= 9'd256;
            n_rows_reg     <= 9'd256;
            cpm_reg        <= 24'd1310720;
            origin_col_reg <= 24'd0;
            origin_row_reg <= 24'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAP_WIDTH:  n_cols_reg     <= cfg_data[8:0];
                REG_MAP_HEIGHT: n_rows_reg     <= cfg_data[8:0];
                REG_CPM:        cpm_reg        <= cfg_data;
                REG_ORIGIN_COL: origin_col_reg <= cfg_data;
                REG_ORIGIN_ROW: origin_row_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gnos_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .req_type        (s_tuser),
        .cell_index      (s_tdata[15:0]),
        .cell_value      (s_tdata[23:16]),
        .point_x         (s_tdata[47:24]),
        .point_y         (s_tdata[71:48]),
        .cells_per_meter (cpm_reg),
        .origin_col      (origin_col_reg),
        .origin_row      (origin_row_reg),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    gnos_queue #(
        .DEPTH (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    gnos_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .SEARCH_RADIUS (SEARCH_RADIUS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .n_cols           (n_cols_reg),
        .n_rows           (n_rows_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .found            (r_found),
        .squared_distance (r_sq),
        .distance         (r_dist)
    );

    assign m_tdata = {6'b0, r_dist, r_sq, r_found};

endmodule

`default_nettype wire

// File: src/gnos_ram.sv
// generic single write port / single read port ram with registered read
// no dependencies
`default_nettype none

module gnos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/gnos_queue.sv
// short fifo of classified items between the front and back parts
// depends on gnos_pkg
`default_nettype none

module gnos_queue import gnos_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire queue_entry_t push_data,
    output logic              full,
    input  wire logic         pop,
    output queue_entry_t      head,
    output logic              empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    queue_entry_t     slot [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [NW-1:0]    count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/gnos_front.sv
// front part: accepts items, scales query points to map cells, classifies loads
// depends on gnos_pkg
`default_nettype none

module gnos_front import gnos_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         req_type,
    input  wire logic [15:0]  cell_index,
    input  wire logic [7:0]   cell_value,
    input  wire logic [23:0]  point_x,
    input  wire logic [23:0]  point_y,
    input  wire logic [23:0]  cells_per_meter,
    input  wire logic [23:0]  origin_col,
    input  wire logic [23:0]  origin_row,
    output logic              push,
    output queue_entry_t      push_data,
    input  wire logic         full
);

    localparam longint STORE_DEPTH = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);

    logic                s1_valid_reg;
    logic                s1_type_reg;
    logic [15:0]         s1_idx_reg;
    logic [7:0]          s1_val_reg;
    logic signed [48:0]  s1_xprod_reg, s1_yprod_reg;

    logic signed [48:0]  xprod, yprod;
    logic signed [49:0]  org_c, org_r, colq, rowq;
    logic signed [17:0]  col_t, row_t;

    assign in_ready = !s1_valid_reg || !full;
    assign push     = s1_valid_reg && !full;

    assign xprod = $signed(point_x) * $signed({1'b0, cells_per_meter});
    assign yprod = $signed(point_y) * $signed({1'b0, cells_per_meter});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_type_reg  <= req_type;
            s1_idx_reg   <= cell_index;
            s1_val_reg   <= cell_value;
            s1_xprod_reg <= xprod;
            s1_yprod_reg <= yprod;
        end
    end

    assign org_c = $signed({{2{origin_col[23]}}, origin_col, 24'b0});
    assign org_r = $signed({{2{origin_row[23]}}, origin_row, 24'b0});
    assign colq  = org_c + $signed({s1_xprod_reg[48], s1_xprod_reg});
    assign rowq  = org_r - $signed({s1_yprod_reg[48], s1_yprod_reg});

    // divide by 2^32 truncating toward zero
    assign col_t = colq[49:32] + 18'(colq[49] && (colq[31:0] != '0));
    assign row_t = rowq[49:32] + 18'(rowq[49] && (rowq[31:0] != '0));

    always_comb begin
        push_data          = '0;
        push_data.is_query = (s1_type_reg == REQ_QUERY);
        push_data.ld_en    = (longint'(s1_idx_reg) < STORE_DEPTH);
        push_data.ld_bit   = (s1_val_reg == OCCUPIED_VALUE);
        push_data.addr     = ENT_AW'(s1_idx_reg);
        push_data.col      = {{(CW-18){col_t[17]}}, col_t};
        push_data.row      = {{(CW-18){row_t[17]}}, row_t};
    end

endmodule

`default_nettype wire

// File: src/gnos_back.sv
// back part: occupancy store, window scan, square root unit and result register
// depends on gnos_pkg and gnos_ram
`default_nettype none

module gnos_back import gnos_pkg::*; #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int SEARCH_RADIUS = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire queue_entry_t head,
    input  wire logic         empty,
    output logic              pop,
    input  wire logic [8:0]   n_cols,
    input  wire logic [8:0]   n_rows,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              found,
    output logic [9:0]        squared_distance,
    output logic [14:0]       distance
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int PRW = WW + YW + 1;
    localparam logic signed [DW-1:0] RAD  = DW'(SEARCH_RADIUS);
    localparam logic signed [DW-1:0] NRAD = -DW'(SEARCH_RADIUS);

    back_state_t state_reg, state_next;

    logic signed [CW-1:0] col_reg, row_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic                 p1_v_reg, p2_v_reg;
    logic [XW-1:0]        p1_nx_reg;
    logic [YW-1:0]        p1_roff_reg;
    logic [SQW-1:0]       p1_sq_reg, p2_sq_reg;
    logic                 found_reg;
    logic [SQW-1:0]       best_reg;
    logic [31:0]          rv_reg;
    logic [15:0]          root_reg;
    logic [19:0]          rem_reg;
    logic [3:0]           step_reg;
    logic                 m_valid_reg;
    logic                 m_found_reg;
    logic [9:0]           m_sq_reg;
    logic [14:0]          m_dist_reg;

    logic [WW-1:0]        wc;
    logic [HW-1:0]        hc;
    logic signed [CW-1:0] nx, ny, roff;
    logic                 inb;
    logic [11:0]          dx2, dy2;
    logic [SQW-1:0]       sq;
    logic                 last_step, drained, out_free, root_last;
    logic [PRW-1:0]       prod, addr_sum;
    logic                 ram_we, rd_bit;
    logic [9:0]           sat;
    logic [19:0]          rem_sh, trial;
    logic [16:0]          rounded;

    assign wc = (32'(n_cols) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(n_cols);
    assign hc = (32'(n_rows) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(n_rows);

    // window cell for the current offsets
    assign nx   = col_reg + {{(CW-DW){dx_reg[DW-1]}}, dx_reg};
    assign ny   = row_reg + {{(CW-DW){dy_reg[DW-1]}}, dy_reg};
    assign inb  = (nx >= 0) && (nx < $signed(CW'(wc))) && (ny >= 0) && (ny < $signed(CW'(hc)));
    assign roff = $signed(CW'(hc)) - CW'(1) - ny;   // flipped row
    assign dx2  = 12'(dx_reg * dx_reg);
    assign dy2  = 12'(dy_reg * dy_reg);
    assign sq   = SQW'(dx2 + dy2);

    assign last_step = (dx_reg == RAD) && (dy_reg == RAD);
    assign drained   = !p1_v_reg && !p2_v_reg;
    assign out_free  = !m_valid_reg || out_ready;
    assign root_last = (step_reg == 4'(ROOT_STEPS - 1));

    assign prod     = PRW'(wc * p1_roff_reg);
    assign addr_sum = prod + PRW'(p1_nx_reg);

    assign ram_we = (state_reg == ST_IDLE) && !empty && !head.is_query && head.ld_en;

    gnos_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head.addr[AW-1:0]),
        .wdata (head.ld_bit),
        .re    (p1_v_reg),
        .raddr (addr_sum[AW-1:0]),
        .rdata (rd_bit)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!empty && head.is_query) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (last_step) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drained) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pop = 1'b0;
        case (state_reg)
            ST_IDLE: pop = !empty;
            default: pop = 1'b0;
        endcase
    end

    assign sat     = (best_reg > SQW'(SQ_MAX)) ? SQ_MAX : best_reg[9:0];
    assign rem_sh  = {rem_reg[17:0], rv_reg[31:30]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rounded = {1'b0, root_reg} + 17'(rem_reg > 20'(root_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_v_reg  <= (state_reg == ST_SCAN) && inb;
            p2_v_reg  <= p1_v_reg;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_nx_reg   <= nx[XW-1:0];
        p1_roff_reg <= roff[YW-1:0];
        p1_sq_reg   <= sq;
        p2_sq_reg   <= p1_sq_reg;

        case (state_reg)
            ST_IDLE: begin
                col_reg   <= head.col;
                row_reg   <= head.row;
                dx_reg    <= NRAD;
                dy_reg    <= NRAD;
                found_reg <= 1'b0;
                best_reg  <= '0;
            end
            ST_SCAN: begin
                if (dx_reg == RAD) begin
                    dx_reg <= NRAD;
                    dy_reg <= dy_reg + 1'b1;
                end else begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                rv_reg   <= {2'b00, sat, 20'b0};
                root_reg <= '0;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            ST_ROOT: begin
                // one result bit per cycle, restoring
                rv_reg   <= {rv_reg[29:0], 2'b00};
                step_reg <= step_reg + 1'b1;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[14:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[14:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_found_reg <= found_reg;
                    m_sq_reg    <= found_reg ? sat : 10'd0;
                    m_dist_reg  <= found_reg ? rounded[14:0] : 15'd0;
                end
            end
            default: ;
        endcase

        if (p2_v_reg && rd_bit && (!found_reg || p2_sq_reg < best_reg)) begin
            found_reg <= 1'b1;
            best_reg  <= p2_sq_reg;
        end
    end

    assign out_valid        = m_valid_reg;
    assign found            = m_found_reg;
    assign squared_distance = m_sq_reg;
    assign distance         = m_dist_reg;

endmodule

`default_nettype wire

// File: sim/gnos_checker.sv
// checker for the grid nearest obstacle search: watches config, input and result channels,
// keeps its own occupancy map and registers, predicts each query result and compares
// depends on gnos_pkg
`timescale 1ns / 1ps

module gnos_checker import gnos_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               n_results,
    output int               n_found
);

    localparam int RADIUS = 20;
    localparam int STORE_DEPTH = 65536;

    // last member in the lowest bits, matching m_tdata
    typedef struct packed {
        logic [14:0] root;
        logic [9:0]  sq;
        logic        found;
    } obstacle_t;

    bit          occ_map [STORE_DEPTH];
    logic [8:0]  map_w, map_h;
    logic [23:0] cpm;
    longint      org_col, org_row;
    obstacle_t   expected_q [$];

    function automatic logic [14:0] root_q10(input longint sq);
        longint v, r, t;
        v = sq << 20;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        if (v > r * r + r) r = r + 1;
        return r[14:0];
    endfunction

    function automatic obstacle_t nearest_obstacle(input logic signed [23:0] px,
                                                   input logic signed [23:0] py);
        obstacle_t res;
        longint colq, rowq, col, row, w, h, nx, ny, addr, best, sqv;
        bit hit;
        colq = org_col * (longint'(1) << 24) + longint'(px) * longint'({1'b0, cpm});
        rowq = org_row * (longint'(1) << 24) - longint'(py) * longint'({1'b0, cpm});
        col = colq / (longint'(1) << 32);
        row = rowq / (longint'(1) << 32);
        w = (map_w > 256) ? 256 : map_w;
        h = (map_h > 256) ? 256 : map_h;
        hit = 0;
        best = 0;
        for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
                nx = col + dx;
                ny = row + dy;
                if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
                addr = w * (h - ny - 1) + nx;
                if (addr < 0 || addr >= STORE_DEPTH) continue;
                if (occ_map[addr]) begin
                    sqv = dx * dx + dy * dy;
                    if (!hit || sqv < best) begin
                        best = sqv;
                        hit = 1;
                    end
                end
            end
        end
        if (best > SQ_MAX) best = SQ_MAX;
        res.found = hit;
        res.sq    = hit ? best[9:0] : '0;
        res.root  = hit ? root_q10(best) : '0;
        return res;
    endfunction

    always @(posedge aclk) begin
        obstacle_t want, got;
        if (!aresetn) begin
            map_w   <= 9'd256;
            map_h   <= 9'd256;
            cpm     <= 24'd1310720;
            org_col <= 0;
            org_row <= 65536;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAP_WIDTH:  map_w <= cfg_data[8:0];
                    REG_MAP_HEIGHT: map_h <= cfg_data[8:0];
                    REG_CPM:        cpm <= cfg_data;
                    REG_ORIGIN_COL: org_col <= longint'($signed(cfg_data));
                    REG_ORIGIN_ROW: org_row <= longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_LOAD)
                    occ_map[s_tdata[15:0]] = (s_tdata[23:16] == OCCUPIED_VALUE);
                else
                    expected_q.insert(expected_q.size(),
                                      nearest_obstacle(s_tdata[47:24], s_tdata[71:48]));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                n_results <= n_results + 1;
                if (expected_q.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: result transfer with nothing expected, got %0d/%0d/%0d",
                             $time, got.found, got.sq, got.root);
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (want.found) n_found <= n_found + 1;
                    if (got !== want || m_tdata[31:26] !== '0) begin
                        errors <= errors + 1;
                        $display("%0t: mismatch expected found=%0d sq=%0d dist=%0d,",
                                 $time, want.found, want.sq, want.root);
                        $display("    got found=%0d sq=%0d dist=%0d fill=%0h",
                                 got.found, got.sq, got.root, m_tdata[31:26]);
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

    initial begin
        errors = 0;
        n_results = 0;
        n_found = 0;
        pending = 0;
    end

endmodule

// File: sim/tb_grid_nearest_obstacle_search.sv
// testbench top for the grid nearest obstacle search: clock, reset, stimulus, verdict
// depends on gnos_pkg, grid_nearest_obstacle_search and gnos_checker
`timescale 1ns / 1ps

module tb_grid_nearest_obstacle_search import gnos_pkg::*;;

    localparam longint CYCLE_LIMIT = 6000000;
    // every map setting below, clamped to the store size, keeps width times height within this many cells
    localparam int FILL_CELLS = 256;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    int errors, pending, n_results, n_found;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_rx = 0;
    longint cycles = 0;
    int n_sent = 0;

    // shadow of the settings, used to aim query points at the map
    int cur_w, cur_h;
    longint cur_cpm, cur_oc, cur_or;

    always #6 aclk = ~aclk;

    grid_nearest_obstacle_search DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    gnos_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .n_results, .n_found
    );

    always @(negedge aclk)
        m_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input logic kind, input logic [71:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_load(input logic [15:0] idx, input logic [7:0] val);
        send(REQ_LOAD, {48'd0, val, idx});
    endtask

    task automatic send_query(input logic [23:0] px, input logic [23:0] py);
        send(REQ_QUERY, {py, px, 24'd0});
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (50) @(posedge aclk);
        @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic configure(input int w, input int h, input longint cpm,
                             input longint oc, input longint orow);
        wait_idle();
        write_reg(REG_MAP_WIDTH, w[23:0]);
        write_reg(REG_MAP_HEIGHT, h[23:0]);
        write_reg(REG_CPM, cpm[23:0]);
        write_reg(REG_ORIGIN_COL, oc[23:0]);
        write_reg(REG_ORIGIN_ROW, orow[23:0]);
        cfg_valid <= 1'b0;
        cur_w = (w > 256) ? 256 : w;
        cur_h = (h > 256) ? 256 : h;
        cur_cpm = cpm;
        cur_oc = oc;
        cur_or = orow;
    endtask

    function automatic logic [23:0] clamp24(input longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    // mostly points aimed in and around the map, sometimes anywhere
    task automatic random_query();
        longint tc, tr, px, py;
        if ($urandom_range(99) < 20) begin
            send_query(24'($urandom), 24'($urandom));
        end else begin
            tc = longint'($urandom_range(cur_w + 50)) - 25;
            tr = longint'($urandom_range(cur_h + 50)) - 25;
            px = (tc * (longint'(1) << 32) - cur_oc * (longint'(1) << 24)) / cur_cpm;
            py = (cur_or * (longint'(1) << 24) - tr * (longint'(1) << 32)) / cur_cpm;
            px = px + longint'($urandom_range(64)) - 32;
            py = py + longint'($urandom_range(64)) - 32;
            send_query(clamp24(px), clamp24(py));
        end
    endtask

    task automatic random_load();
        logic [15:0] idx;
        logic [7:0]  val;
        idx = ($urandom_range(3) == 0 || cur_w * cur_h == 0) ?
              16'($urandom) : 16'($urandom_range(cur_w * cur_h - 1));
        val = ($urandom_range(3) == 0) ? OCCUPIED_VALUE : 8'($urandom);
        send_load(idx, val);
    endtask

    task automatic pick_settings(input int sel);
        int w, h;
        case (sel)
            0: configure(16, 16, 1310720, 0, 16 * 256);
            1: configure(1, 1, 65536, 0, 256);
            2: configure(511, 1, 16777215, -8388608, 8388607);
            3: configure(0, 40, 1310720, 0, 40 * 256);
            4: configure(32, 8, 1310720, 5 * 256, 8 * 256);
            default: begin
                w = $urandom_range(4, 16);
                h = $urandom_range(4, 16);
                configure(w, h, $urandom_range(32768, 1 << 20),
                          $urandom_range(w * 256), $urandom_range(h * 256));
            end
        endcase
    endtask

    initial begin
        int chunk_sel [8] = '{5, 0, 4, 5, 2, 1, 3, 5};
        int idle_s [4] = '{0, 71, 0, 36};
        int stall_r [4] = '{0, 0, 71, 36};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // every cell that any setting below can read is loaded before the first query
        for (int i = 0; i < FILL_CELLS; i++)
            send_load(i[15:0], ($urandom_range(99) < 4) ? OCCUPIED_VALUE : 8'($urandom));

        pick_settings(0);
        send_load(16'd0, 8'h80);
        send_load(16'hFFFF, 8'd127);
        send_load(16'd300, 8'd99);
        send_load(16'd200, OCCUPIED_VALUE);
        send_query(24'd0, 24'd0);
        send_query(24'h7FFFFF, 24'h7FFFFF);
        send_query(24'h800000, 24'h800000);
        send_query(24'h7FFFFF, 24'h800000);
        send_query(24'd65536, -24'sd65536);
        send_query(24'd20000, 24'd30000);
        send_load(16'd0, OCCUPIED_VALUE);
        send_query(24'd0, 24'd3277);
        pick_settings(1);
        send_load(16'd0, 8'd1);
        send_query(24'd0, 24'd0);
        send_load(16'd0, OCCUPIED_VALUE);
        send_query(24'd0, 24'd0);
        send_query(24'd1000000, 24'd0);
        pick_settings(3);
        send_query(24'd0, 24'd0);
        pick_settings(2);
        send_query(24'h7FFFFF, 24'h7FFFFF);
        send_query(24'h800000, 24'h000001);
        // height above the store, one column
        configure(1, 300, 65536, 0, 200 * 256);
        send_query(24'd0, 24'd0);

        for (int c = 0; c < 8; c++) begin
            wait_idle();
            send_idle_pct = idle_s[c % 4];
            recv_stall_pct = stall_r[c % 4];
            pick_settings(chunk_sel[c]);
            repeat (25) begin
                if ($urandom_range(99) < 40) random_query();
                else random_load();
            end
        end

        // receiver held off for a long stretch while the sender keeps offering
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pick_settings(0);
        fork
            begin
                hold_rx = 1;
                repeat (20000) @(posedge aclk);
                hold_rx = 0;
            end
            begin
                repeat (40) begin
                    if ($urandom_range(1) == 0) random_query();
                    else random_load();
                end
                s_tvalid <= 1'b0;
            end
        join

        do @(posedge aclk); while (pending != 0);
        repeat (2000) @(posedge aclk);

        $display("sent %0d items (%0d to fill the map area), checked %0d results, %0d hits",
                 n_sent, FILL_CELLS, n_results, n_found);
        $display("covered map sizes 0, 1, partial and above the store, idle and stall mixes");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/gnos_pkg.sv
src/gnos_ram.sv
src/gnos_queue.sv
src/gnos_front.sv
src/gnos_back.sv
src/grid_nearest_obstacle_search.sv
sim/gnos_checker.sv
sim/tb_grid_nearest_obstacle_search.sv
